### rtl/core/tempo_pulse_tone_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Tempo pulse tone generator assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEMPO_PULSE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define TEMPO_PULSE_TONE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TPTG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tptg_pkg.sv
// ----------------------------------------------------------------------------
// tptg_pkg
// Shared types, constants and table builders of the tempo pulse tone
// generator.
// ----------------------------------------------------------------------------
package tptg_pkg;

    localparam int SINE_TABLE_BITS_DEF  = 8;
    localparam int DECAY_TABLE_BITS_DEF = 8;
    localparam int SAMPLE_BITS_DEF      = 16;

    localparam int ENV_BITS = 17;
    localparam logic [ENV_BITS-1:0] ENV_ONE = 17'h10000;

    localparam logic signed [33:0] TTN_MAX = 34'sh1_FFFF_FFFF;
    localparam logic signed [33:0] TTN_MIN = 34'sh2_0000_0000;
    localparam logic [31:0] ONE_SAMPLE_Q16 = 32'h0001_0000;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_RESYNC = 1'b1;

    localparam longint unsigned Q30_ONE    = 64'd1 << 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [2:0] {
        REG_ENABLE         = 3'd0,
        REG_PULSE_INTERVAL = 3'd1,
        REG_PULSE_LENGTH   = 3'd2,
        REG_ATTACK_LENGTH  = 3'd3,
        REG_ATTACK_STEP    = 3'd4,
        REG_DECAY_STEP     = 3'd5,
        REG_TONE_STEP      = 3'd6,
        REG_GAIN           = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_COMMIT,
        ST_SCALE,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic signed [33:0] ttn;
        logic               on;
        logic [12:0]        idx;
    } timing_t;

    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint          sum;
        longint unsigned t;
        sum = longint'(x);
        t   = x;
        for (int n = 1; n <= 6; n++)
        begin
            t = (((t * x) >> 30) * x) >> 30;
            t = t / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        return longint'(sum);
    endfunction

    function automatic int sine_entry(input int k, input int stb, input int sb);
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        longint unsigned a;
        longint unsigned x;
        longint unsigned amp;
        longint unsigned mag;
        quarter = 64'd1 << (stb - 2);
        q       = (64'(k) >> (stb - 2)) & 64'd3;
        r       = 64'(k) & (quarter - 64'd1);
        a       = (q[0]) ? (quarter - r) : r;
        x       = (a * TWO_PI_Q30) >> stb;
        amp     = (64'd1 << (sb - 1)) - 64'd1;
        mag     = (sin_q30(x) * amp + (64'd1 << 29)) >> 30;
        return q[1] ? -int'(mag) : int'(mag);
    endfunction

    function automatic int decay_entry(input int j, input int dtb);
        longint unsigned y;
        longint unsigned z;
        longint          sum;
        longint unsigned t;
        longint unsigned s;
        y   = ((64'd5 << 30) * 64'(j)) >> dtb;
        z   = y >> 4;
        sum = longint'(Q30_ONE);
        t   = Q30_ONE;
        for (int n = 1; n <= 10; n++)
        begin
            t = ((t * z) >> 30) / 64'(n);
            if (n % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        s = 64'(sum);
        for (int n = 0; n < 4; n++)
        begin
            s = (s * s + (64'd1 << 29)) >> 30;
        end
        return int'((s + (64'd1 << 13)) >> 14);
    endfunction

endpackage

### rtl/core/tptg_tables.sv
// ----------------------------------------------------------------------------
// tptg_tables
// Sine and exponential decay lookup tables with registered read data.
// ----------------------------------------------------------------------------
module tptg_tables #(
    parameter int SINE_TABLE_BITS  = tptg_pkg::SINE_TABLE_BITS_DEF,
    parameter int DECAY_TABLE_BITS = tptg_pkg::DECAY_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS      = tptg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic [SINE_TABLE_BITS-1:0]        sine_addr,
    input  logic [DECAY_TABLE_BITS-1:0]       decay_addr,
    output logic signed [SAMPLE_BITS-1:0]     sine_q,
    output logic [tptg_pkg::ENV_BITS-1:0]     decay_q
);

    localparam int SINE_DEPTH  = 2 ** SINE_TABLE_BITS;
    localparam int DECAY_DEPTH = 2 ** DECAY_TABLE_BITS;

    logic signed [SAMPLE_BITS-1:0]     sine_rom  [SINE_DEPTH];
    logic [tptg_pkg::ENV_BITS-1:0]     decay_rom [DECAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0]     sine_q_reg;
    logic [tptg_pkg::ENV_BITS-1:0]     decay_q_reg;

    for (genvar k = 0; k < SINE_DEPTH; k++)
    begin : g_sine
        localparam int SV = tptg_pkg::sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS);
        assign sine_rom[k] = SAMPLE_BITS'(SV);
    end

    for (genvar j = 0; j < DECAY_DEPTH; j++)
    begin : g_decay
        localparam int DV = tptg_pkg::decay_entry(j, DECAY_TABLE_BITS);
        assign decay_rom[j] = tptg_pkg::ENV_BITS'(DV);
    end

    always_ff @(posedge clk)
    begin
        sine_q_reg  <= sine_rom[sine_addr];
        decay_q_reg <= decay_rom[decay_addr];
    end

    assign sine_q  = sine_q_reg;
    assign decay_q = decay_q_reg;

endmodule

### rtl/core/tempo_pulse_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// tempo_pulse_tone_generator_unit
// Pulse clock with a tone burst per pulse; timing state kept in a one-entry
// synchronous memory that is read, updated and written back per beat.
//
//   channel | signals                                      | direction
//   in      | in_valid, in_stall, req_type, phase_valid,   | sink
//           | pulse_fraction                               |
//   out     | out_valid, out_stall, pulse_sample,          | source
//           | pulse_active, pulse_start                    |
//   cfg     | cfg_we, cfg_index, cfg_data                  | sink, no stall
//
// A tick beat passes from accept to the next accept through state read,
// pulse decision, write-back with table lookup, then two scaling multiplies.
// A resync beat ends after the write-back and gives no output beat.
// Reset leaves the timing state zero (memory entry marked not yet written).
// Output register decouples the sides; a stalled output holds the final step.
// ----------------------------------------------------------------------------
`include "tempo_pulse_tone_generator_unit_assert.svh"

module tempo_pulse_tone_generator_unit #(
    parameter int SINE_TABLE_BITS  = tptg_pkg::SINE_TABLE_BITS_DEF,
    parameter int DECAY_TABLE_BITS = tptg_pkg::DECAY_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS      = tptg_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic               phase_valid,
    input  logic [15:0]        pulse_fraction,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pulse_sample,
    output logic               pulse_active,
    output logic               pulse_start,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int EB    = tptg_pkg::ENV_BITS;
    localparam int P1W   = SAMPLE_BITS + EB - 1;
    localparam int P2W   = P1W + 16;
    localparam int RW    = P2W + 1;
    localparam int SHIFT = SAMPLE_BITS + 16;

    // configuration
    logic        enable_reg;
    logic [31:0] pulse_interval_reg;
    logic [12:0] pulse_length_reg;
    logic [9:0]  attack_length_reg;
    logic [15:0] attack_step_reg;
    logic [15:0] decay_step_reg;
    logic [14:0] tone_step_reg;
    logic [15:0] gain_reg;

    tptg_pkg::seq_state_t state_reg, state_next;

    logic        req_type_reg;
    logic        phase_valid_reg;
    logic [15:0] frac_reg;

    tptg_pkg::timing_t state_mem [0:0];
    tptg_pkg::timing_t st_rd_reg;
    logic              st_valid_reg;
    logic              st_we;
    tptg_pkg::timing_t st_wdata;
    tptg_pkg::timing_t cur;

    logic signed [33:0] ttn1_reg;
    logic               on1_reg;
    logic [12:0]        idx1_reg;
    logic               start_reg;
    logic               active_reg;
    logic               silent_reg;
    logic               use_decay_reg;
    logic [SINE_TABLE_BITS-1:0] sine_addr_reg;
    logic [28:0]        att_prod_reg;
    logic [28:0]        dec_prod_reg;
    logic [31:0]        pos_reg;
    logic [EB-1:0]      env_att_reg;
    logic [P1W-1:0]     prod1_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic signed [15:0] pulse_sample_reg;
    logic               pulse_active_reg;
    logic               pulse_start_reg;

    logic                          accept;
    logic                          out_load;
    logic signed [SAMPLE_BITS-1:0] sine_q;
    logic [EB-1:0]                 decay_q;
    logic [DECAY_TABLE_BITS-1:0]   decay_addr;

    // pulse decision
    logic               start;
    logic signed [33:0] ttn1;
    logic               on1;
    logic [12:0]        idx1;
    logic [27:0]        phase_prod;
    logic [12:0]        dec_diff;
    logic [47:0]        pos_prod;

    // write-back
    logic [34:0]        ttn_sub;
    logic [12:0]        idx_inc;
    tptg_pkg::timing_t  tick_next;
    tptg_pkg::timing_t  sync_next;
    logic               sync_on;

    // scaling
    logic [SAMPLE_BITS-1:0] sine_abs;
    logic [EB-1:0]          env;
    logic [P2W-1:0]         prod2;
    logic [RW-1:0]          rounded;
    logic [16:0]            mag;
    logic signed [15:0]     sample_val;

    function automatic logic signed [33:0] sat34(input logic [34:0] v);
        if (v[34] != v[33])
            sat34 = v[34] ? tptg_pkg::TTN_MIN : tptg_pkg::TTN_MAX;
        else
            sat34 = v[33:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b0;
            pulse_interval_reg <= 32'd65536000;
            pulse_length_reg   <= 13'd1056;
            attack_length_reg  <= 10'd105;
            attack_step_reg    <= 16'd624;
            decay_step_reg     <= 16'd69;
            tone_step_reg      <= 15'd1365;
            gain_reg           <= 16'd6554;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tptg_pkg::REG_ENABLE:         enable_reg         <= cfg_data[0];
                tptg_pkg::REG_PULSE_INTERVAL: pulse_interval_reg <= cfg_data;
                tptg_pkg::REG_PULSE_LENGTH:   pulse_length_reg   <= cfg_data[12:0];
                tptg_pkg::REG_ATTACK_LENGTH:  attack_length_reg  <= cfg_data[9:0];
                tptg_pkg::REG_ATTACK_STEP:    attack_step_reg    <= cfg_data[15:0];
                tptg_pkg::REG_DECAY_STEP:     decay_step_reg     <= cfg_data[15:0];
                tptg_pkg::REG_TONE_STEP:      tone_step_reg      <= cfg_data[14:0];
                tptg_pkg::REG_GAIN:           gain_reg           <= cfg_data[15:0];
                default:                      enable_reg         <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tptg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        st_we      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            tptg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = tptg_pkg::ST_PREP;
            end
            tptg_pkg::ST_PREP:
                state_next = tptg_pkg::ST_COMMIT;
            tptg_pkg::ST_COMMIT:
            begin
                st_we = 1'b1;
                if (req_type_reg == tptg_pkg::REQ_RESYNC)
                    state_next = tptg_pkg::ST_IDLE;
                else
                    state_next = tptg_pkg::ST_SCALE;
            end
            tptg_pkg::ST_SCALE:
                state_next = tptg_pkg::ST_EMIT;
            tptg_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = tptg_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tptg_pkg::ST_IDLE;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg    <= req_type;
            phase_valid_reg <= phase_valid;
            frac_reg        <= pulse_fraction;
        end
    end

    // timing state memory
    always_ff @(posedge clk)
    begin
        if (st_we)
            state_mem[0] <= st_wdata;
        if (accept)
            st_rd_reg <= state_mem[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (st_we)
            st_valid_reg <= 1'b1;
    end

    assign cur = st_valid_reg ? st_rd_reg : '0;

    always_comb
    begin
        start      = enable_reg && (cur.ttn <= 34'sd0) && !cur.on;
        ttn1       = start ? sat34(35'(cur.ttn) + 35'(pulse_interval_reg)) : cur.ttn;
        on1        = cur.on | start;
        idx1       = start ? 13'd0 : cur.idx;
        phase_prod = 28'(idx1) * 28'(tone_step_reg);
        dec_diff   = idx1 - 13'(attack_length_reg);
        pos_prod   = 48'(frac_reg) * 48'(pulse_interval_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tptg_pkg::ST_PREP)
        begin
            ttn1_reg      <= ttn1;
            on1_reg       <= on1;
            idx1_reg      <= idx1;
            start_reg     <= start;
            active_reg    <= enable_reg && on1;
            silent_reg    <= !(enable_reg && on1) || (idx1 >= pulse_length_reg);
            use_decay_reg <= idx1 >= 13'(attack_length_reg);
            sine_addr_reg <= phase_prod[15 -: SINE_TABLE_BITS];
            att_prod_reg  <= 29'(idx1) * 29'(attack_step_reg);
            dec_prod_reg  <= 29'(dec_diff) * 29'(decay_step_reg);
            pos_reg       <= pos_prod[47:16];
        end
    end

    always_comb
    begin
        ttn_sub       = 35'(ttn1_reg) - 35'(tptg_pkg::ONE_SAMPLE_Q16);
        idx_inc       = idx1_reg + 13'd1;
        tick_next.ttn = enable_reg ? sat34(ttn_sub) : ttn1_reg;
        tick_next.on  = on1_reg;
        tick_next.idx = idx1_reg;
        if (active_reg)
        begin
            if (idx_inc == 13'd0 || idx_inc >= pulse_length_reg)
            begin
                tick_next.on  = 1'b0;
                tick_next.idx = 13'd0;
            end
            else
            begin
                tick_next.on  = 1'b1;
                tick_next.idx = idx_inc;
            end
        end

        sync_on = pos_reg[31:16] < 16'(pulse_length_reg);
        if (phase_valid_reg)
        begin
            sync_next.ttn = 34'(pulse_interval_reg) - 34'(pos_reg);
            sync_next.on  = sync_on;
            sync_next.idx = sync_on ? pos_reg[28:16] : 13'd0;
        end
        else
        begin
            sync_next = '0;
        end

        st_wdata = (req_type_reg == tptg_pkg::REQ_RESYNC) ? sync_next : tick_next;

        decay_addr = (dec_prod_reg[28:16] != 13'd0) ? '1 : dec_prod_reg[15 -: DECAY_TABLE_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tptg_pkg::ST_COMMIT)
            env_att_reg <= (att_prod_reg > 29'(tptg_pkg::ENV_ONE)) ?
                           tptg_pkg::ENV_ONE : att_prod_reg[EB-1:0];
    end

    tptg_tables #(
        .SINE_TABLE_BITS  (SINE_TABLE_BITS),
        .DECAY_TABLE_BITS (DECAY_TABLE_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_tables (
        .clk        (clk),
        .sine_addr  (sine_addr_reg),
        .decay_addr (decay_addr),
        .sine_q     (sine_q),
        .decay_q    (decay_q)
    );

    always_comb
    begin
        sine_abs = sine_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sine_q) : SAMPLE_BITS'(sine_q);
        env      = use_decay_reg ? decay_q : env_att_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tptg_pkg::ST_SCALE)
        begin
            prod1_reg <= P1W'(sine_abs[SAMPLE_BITS-2:0]) * P1W'(env);
            neg_reg   <= sine_q[SAMPLE_BITS-1];
        end
    end

    always_comb
    begin
        prod2   = P2W'(prod1_reg) * P2W'(gain_reg);
        rounded = RW'(prod2) + (RW'(1) << (SHIFT - 1));
        mag     = 17'(rounded >> SHIFT);
        if (neg_reg)
            sample_val = 16'(-((mag > 17'd32768) ? 17'd32768 : mag));
        else
            sample_val = 16'((mag > 17'd32767) ? 17'd32767 : mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pulse_sample_reg <= silent_reg ? 16'sd0 : sample_val;
            pulse_active_reg <= active_reg;
            pulse_start_reg  <= start_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pulse_sample = pulse_sample_reg;
    assign pulse_active = pulse_active_reg;
    assign pulse_start  = pulse_start_reg;

    `TPTG_ASSERT_IMPL(a_start_is_active, out_valid && pulse_start, pulse_active, "pulse start beat without active burst")
    `TPTG_ASSERT_IMPL(a_quiet_when_off, out_valid && !pulse_active, pulse_sample == 16'sd0, "nonzero sample outside a burst")
    `TPTG_ASSERT_NEXT(a_resync_no_beat, state_reg == tptg_pkg::ST_COMMIT && req_type_reg == tptg_pkg::REQ_RESYNC, state_reg == tptg_pkg::ST_IDLE && !out_load, "resync produced an output beat")

endmodule

### tb/tb_tempo_pulse_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// Tempo pulse tone generator testbench
// Drives tick and resync beats through bursts and gaps against a stalling
// receiver, predicts every output beat from a cycle-free model of the pulse
// timing, envelope and tone tables, and checks each field in order.
// Runs directed corner cases, several register settings including both
// extremes, a random mix, and a calm run of back-to-back ticks with no
// pulse interval.
// ----------------------------------------------------------------------------
module tb_tempo_pulse_tone_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SINE_BITS  = tptg_pkg::SINE_TABLE_BITS_DEF;
    localparam int DECAY_BITS = tptg_pkg::DECAY_TABLE_BITS_DEF;
    localparam int SMP_BITS   = tptg_pkg::SAMPLE_BITS_DEF;
    localparam int SINE_SIZE  = 1 << SINE_BITS;
    localparam int DECAY_SIZE = 1 << DECAY_BITS;
    localparam int unsigned DECAY_LAST = DECAY_SIZE - 1;
    localparam int unsigned ENV_UNIT   = 65536;

    localparam longint unsigned Q30_UNIT = 64'd1 << 30;
    localparam longint unsigned TAU_Q30  = 64'd6746518852;
    localparam longint TTN_TOP   = 64'sd8589934591;
    localparam longint TTN_FLOOR = -64'sd8589934592;

    localparam int RAND_PHASES    = 8;
    localparam int ITEMS_PER_PH   = 220;
    localparam int SAT_TICKS      = 120;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 3000000;

    typedef struct packed {
        logic        kind;
        logic        ph_valid;
        logic [15:0] frac;
    } beat_req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
        logic               start;
    } tone_beat_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic               req_type       = tptg_pkg::REQ_TICK;
    logic               phase_valid    = 1'b0;
    logic [15:0]        pulse_fraction = 16'd0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic signed [15:0] pulse_sample;
    logic               pulse_active;
    logic               pulse_start;
    logic               cfg_we         = 1'b0;
    logic [2:0]         cfg_index      = tptg_pkg::REG_ENABLE;
    logic [31:0]        cfg_data       = 32'd0;

    // register shadow
    logic        cfg_enable;
    logic [31:0] cfg_interval;
    logic [12:0] cfg_length;
    logic [9:0]  cfg_attack_len;
    logic [15:0] cfg_attack_step;
    logic [15:0] cfg_decay_step;
    logic [14:0] cfg_tone_step;
    logic [15:0] cfg_gain;

    // timing state
    longint      ttn;
    logic        click_on;
    logic [12:0] click_idx;

    int          sine_lut  [SINE_SIZE];
    int unsigned decay_lut [DECAY_SIZE];

    beat_req_t   stim_q [$];
    tone_beat_t  tone_q [$];
    beat_req_t   cur_req;
    tone_beat_t  got_beat;
    tone_beat_t  want_beat;

    int          mism_count = 0;
    int          burst_left;
    int          gap_left;
    int unsigned rx_cyc;
    int          hold_left;
    logic        calm = 1'b0;

    tempo_pulse_tone_generator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .phase_valid    (phase_valid),
        .pulse_fraction (pulse_fraction),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pulse_sample   (pulse_sample),
        .pulse_active   (pulse_active),
        .pulse_start    (pulse_start),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_ttn(input longint v);
        if (v > TTN_TOP)
            return TTN_TOP;
        if (v < TTN_FLOOR)
            return TTN_FLOOR;
        return v;
    endfunction

    task automatic build_luts();
        longint unsigned x;
        longint unsigned t;
        longint unsigned mag;
        longint unsigned z;
        longint unsigned s;
        longint          acc;
        int unsigned     quad;
        int unsigned     off;
        int unsigned     a;
        int unsigned     quarter;
        quarter = 1 << (SINE_BITS - 2);
        for (int k = 0; k < SINE_SIZE; k++)
        begin
            quad = (k >> (SINE_BITS - 2)) & 3;
            off  = k & (quarter - 1);
            a    = quad[0] ? quarter - off : off;
            x    = (64'(a) * TAU_Q30) >> SINE_BITS;
            acc  = longint'(x);
            t    = x;
            for (int n = 1; n <= 6; n++)
            begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(t);
                else
                    acc = acc + longint'(t);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(Q30_UNIT))
                acc = longint'(Q30_UNIT);
            mag = (64'(acc) * ((64'd1 << (SMP_BITS - 1)) - 64'd1) + (64'd1 << 29)) >> 30;
            sine_lut[k] = quad[1] ? -int'(mag) : int'(mag);
        end
        for (int j = 0; j < DECAY_SIZE; j++)
        begin
            z   = (((64'd5 << 30) * 64'(j)) >> DECAY_BITS) >> 4;
            acc = longint'(Q30_UNIT);
            t   = Q30_UNIT;
            for (int n = 1; n <= 10; n++)
            begin
                t = ((t * z) >> 30) / 64'(n);
                if (n % 2 == 1)
                    acc = acc - longint'(t);
                else
                    acc = acc + longint'(t);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(Q30_UNIT))
                acc = longint'(Q30_UNIT);
            s = 64'(acc);
            for (int n = 0; n < 4; n++)
            begin
                s = (s * s + (64'd1 << 29)) >> 30;
            end
            decay_lut[j] = 32'((s + (64'd1 << 13)) >> 14);
        end
    endtask

    task automatic predict_beat(input beat_req_t req);
        longint unsigned pos;
        longint unsigned prod;
        longint          level;
        int unsigned     phase;
        int unsigned     env;
        int unsigned     dpos;
        int unsigned     addr;
        int              wave;
        tone_beat_t      beat;
        beat = '0;
        if (req.kind == tptg_pkg::REQ_RESYNC)
        begin
            if (req.ph_valid)
            begin
                pos = (64'(req.frac) * 64'(cfg_interval)) >> 16;
                ttn = clamp_ttn(longint'({32'd0, cfg_interval}) - longint'(pos));
                if (pos < (64'(cfg_length) << 16))
                begin
                    click_on  = 1'b1;
                    click_idx = pos[28:16];
                end
                else
                begin
                    click_on  = 1'b0;
                    click_idx = '0;
                end
            end
            else
            begin
                ttn       = 0;
                click_on  = 1'b0;
                click_idx = '0;
            end
        end
        else
        begin
            if (cfg_enable)
            begin
                if (ttn <= 0 && !click_on)
                begin
                    click_on   = 1'b1;
                    click_idx  = '0;
                    ttn        = clamp_ttn(ttn + longint'({32'd0, cfg_interval}));
                    beat.start = 1'b1;
                end
                if (click_on)
                begin
                    beat.active = 1'b1;
                    if (click_idx < cfg_length)
                    begin
                        phase = (32'(click_idx) * 32'(cfg_tone_step)) & 32'hFFFF;
                        wave  = sine_lut[phase >> (16 - SINE_BITS)];
                        if (click_idx < cfg_attack_len)
                        begin
                            env = 32'(click_idx) * 32'(cfg_attack_step);
                            if (env > ENV_UNIT)
                                env = ENV_UNIT;
                        end
                        else
                        begin
                            dpos = (32'(click_idx) - 32'(cfg_attack_len)) * 32'(cfg_decay_step);
                            addr = dpos >> (16 - DECAY_BITS);
                            if (addr > DECAY_LAST)
                                addr = DECAY_LAST;
                            env = decay_lut[addr];
                        end
                        prod = 64'((wave < 0) ? -wave : wave) * 64'(env) * 64'(cfg_gain);
                        prod = (prod + (64'd1 << (SMP_BITS + 15))) >> (SMP_BITS + 16);
                        if (wave < 0)
                            level = -longint'((prod > 64'd32768) ? 64'd32768 : prod);
                        else
                            level = longint'((prod > 64'd32767) ? 64'd32767 : prod);
                        beat.sample = level[15:0];
                    end
                    click_idx = click_idx + 13'd1;
                    if (click_idx == 13'd0 || click_idx >= cfg_length)
                    begin
                        click_on  = 1'b0;
                        click_idx = '0;
                    end
                end
                ttn = clamp_ttn(ttn - 64'sd65536);
            end
            tone_q.push_back(beat);
        end
    endtask

    task automatic write_reg(input tptg_pkg::cfg_index_t r, input logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            tptg_pkg::REG_ENABLE:         cfg_enable      = v[0];
            tptg_pkg::REG_PULSE_INTERVAL: cfg_interval    = v;
            tptg_pkg::REG_PULSE_LENGTH:   cfg_length      = v[12:0];
            tptg_pkg::REG_ATTACK_LENGTH:  cfg_attack_len  = v[9:0];
            tptg_pkg::REG_ATTACK_STEP:    cfg_attack_step = v[15:0];
            tptg_pkg::REG_DECAY_STEP:     cfg_decay_step  = v[15:0];
            tptg_pkg::REG_TONE_STEP:      cfg_tone_step   = v[14:0];
            default:                      cfg_gain        = v[15:0];
        endcase
    endtask

    task automatic apply_settings(input logic en, input logic [31:0] interval,
                                  input logic [12:0] len, input logic [9:0] alen,
                                  input logic [15:0] astep, input logic [15:0] dstep,
                                  input logic [14:0] tstep, input logic [15:0] g);
        write_reg(tptg_pkg::REG_ENABLE, {31'd0, en});
        write_reg(tptg_pkg::REG_PULSE_INTERVAL, interval);
        write_reg(tptg_pkg::REG_PULSE_LENGTH, {19'd0, len});
        write_reg(tptg_pkg::REG_ATTACK_LENGTH, {22'd0, alen});
        write_reg(tptg_pkg::REG_ATTACK_STEP, {16'd0, astep});
        write_reg(tptg_pkg::REG_DECAY_STEP, {16'd0, dstep});
        write_reg(tptg_pkg::REG_TONE_STEP, {17'd0, tstep});
        write_reg(tptg_pkg::REG_GAIN, {16'd0, g});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++)
            stim_q.push_back('{kind: tptg_pkg::REQ_TICK, ph_valid: 1'b0, frac: 16'd0});
    endtask

    task automatic add_resync(input logic v, input logic [15:0] f);
        stim_q.push_back('{kind: tptg_pkg::REQ_RESYNC, ph_valid: v, frac: f});
    endtask

    task automatic settle();
        while (stim_q.size() != 0 || in_valid || tone_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string msg);
        mism_count++;
        if (mism_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    // sender: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            req_type       <= tptg_pkg::REQ_TICK;
            phase_valid    <= 1'b0;
            pulse_fraction <= 16'd0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_beat(cur_req);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() != 0)
                begin
                    cur_req = stim_q.pop_front();
                    in_valid       <= 1'b1;
                    req_type       <= cur_req.kind;
                    phase_valid    <= cur_req.ph_valid;
                    pulse_fraction <= cur_req.frac;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = (calm || $urandom_range(0, 2) == 0) ? 0
                                                                       : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern with two long holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_cyc    = 0;
            hold_left = 0;
        end
        else
        begin
            rx_cyc++;
            if (rx_cyc == 1500 || rx_cyc == 6000)
                hold_left = 300;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                case (rx_cyc[10:9])
                    2'd0:    out_stall <= 1'b0;
                    2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
                    2'd2:    out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (rx_cyc % 7 < 3);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_beat = '{sample: pulse_sample, active: pulse_active, start: pulse_start};
            if (tone_q.size() == 0)
                flag_mismatch($sformatf("unexpected beat sample=%0d active=%0b start=%0b",
                                        got_beat.sample, got_beat.active, got_beat.start));
            else
            begin
                want_beat = tone_q.pop_front();
                if (got_beat !== want_beat)
                    flag_mismatch($sformatf(
                        "sample %0d/%0d active %0b/%0b start %0b/%0b (expected/actual)",
                        want_beat.sample, got_beat.sample, want_beat.active,
                        got_beat.active, want_beat.start, got_beat.start));
            end
        end
    end

    initial
    begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int          r;
        logic [12:0] len_v;
        logic [9:0]  atk_v;
        logic        en_v;
        build_luts();
        cfg_enable      = 1'b0;
        cfg_interval    = 32'd65536000;
        cfg_length      = 13'd1056;
        cfg_attack_len  = 10'd105;
        cfg_attack_step = 16'd624;
        cfg_decay_step  = 16'd69;
        cfg_tone_step   = 15'd1365;
        cfg_gain        = 16'd6554;
        ttn       = 0;
        click_on  = 1'b0;
        click_idx = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: silent ticks, resync still applies
        add_ticks(1);
        add_resync(1'b1, 16'hFFFF);
        add_ticks(1);
        add_resync(1'b0, 16'h0000);
        add_ticks(1);
        settle();

        // short pulse: attack overshoot, decay past the end, resync positions
        apply_settings(1'b1, 32'h0003_8000, 13'd5, 10'd3, 16'hFFFF, 16'hFFFF,
                       15'h7FFF, 16'hFFFF);
        add_ticks(9);
        add_resync(1'b1, 16'h0000);
        add_ticks(2);
        add_resync(1'b1, 16'hFFFF);
        add_ticks(2);
        add_resync(1'b1, 16'h8000);
        add_resync(1'b0, 16'h1234);
        add_ticks(2);
        settle();

        // zero pulse length
        apply_settings(1'b1, 32'h0001_0000, 13'd0, 10'd0, 16'd0, 16'd0, 15'd0, 16'd0);
        add_ticks(4);
        add_resync(1'b1, 16'h0001);
        add_ticks(1);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                apply_settings(1'b1, 32'hFFFF_FFFF, 13'h1FFF, 10'h3FF, 16'hFFFF, 16'hFFFF,
                               15'h7FFF, 16'hFFFF);
            else if (ph == 1)
                apply_settings(1'b1, 32'd0, 13'd0, 10'd0, 16'd0, 16'd0, 15'd0, 16'd0);
            else
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    len_v = 13'd0;
                else if (r == 9)
                    len_v = 13'($urandom_range(1000, 8191));
                else
                    len_v = 13'($urandom_range(1, 64));
                atk_v = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, 24));
                en_v  = (ph != 2);
                apply_settings(en_v,
                               (32'($urandom_range(1, 48)) << 16) | 32'($urandom_range(0, 65535)),
                               len_v, atk_v, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
                               16'($urandom_range(0, 65535)));
            end
            for (int i = 0; i < ITEMS_PER_PH; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    add_ticks(1);
                else
                    add_resync(r < 94, 16'($urandom_range(0, 65535)));
            end
            settle();
        end

        // back-to-back ticks with no pulse interval
        calm = 1'b1;
        apply_settings(1'b1, 32'd0, 13'h1FFF, 10'd200, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
                       16'($urandom_range(0, 65535)));
        add_resync(1'b0, 16'h0000);
        add_ticks(SAT_TICKS);
        settle();
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mism_count == 0 && tone_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tptg_pkg.sv
rtl/core/tptg_tables.sv
rtl/core/tempo_pulse_tone_generator_unit.sv
tb/tb_tempo_pulse_tone_generator_unit.sv
